[hw/rtl/occupancy_decimating_frame_queue_top_macros.svh]
// Assertion macros for the frame queue top level.
`ifndef OCCUPANCY_DECIMATING_FRAME_QUEUE_TOP_MACROS_SVH
`define OCCUPANCY_DECIMATING_FRAME_QUEUE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every clock edge outside reset.
`define ODFQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odfq: same-cycle check failed");
// Next-cycle implication.
`define ODFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odfq: next-cycle check failed");
`else
`define ODFQ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ODFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/odfq_pkg.sv]
// Types, codes and defaults for the occupancy-decimating frame queue.
package odfq_pkg;

   // Default geometry
   localparam int DECIM_STEP_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 32;

   // Fixed field widths
   localparam int CTR_W    = 32;
   localparam int TIME_W   = 64;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 6;

   // Commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   // Register indexes (byte address bit 2)
   localparam logic REG_LATEST_ONLY = 1'b0;
   localparam logic REG_ALLOW_DROP  = 1'b1;

   typedef struct packed {
      logic                command;
      logic [TIME_W-1:0]   capture_time;
      logic [TIME_W-1:0]   display_time;
      logic [HANDLE_W-1:0] frame_handle;
      logic                end_marker;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TIME_W-1:0]   head_capture_time;
      logic [TIME_W-1:0]   head_display_time;
      logic [HANDLE_W-1:0] head_frame_handle;
      logic                head_end_marker;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // One stored descriptor
   typedef struct packed {
      logic [TIME_W-1:0]   capture_time;
      logic [TIME_W-1:0]   display_time;
      logic [HANDLE_W-1:0] frame_handle;
      logic                end_marker;
   } entry_type;

   // Status from the modulo unit to the sequencer
   typedef struct packed {
      logic done;
      logic zero;
   } mod_status_type;

endpackage

[hw/rtl/odfq_mem.sv]
// Descriptor memory: one write port, one read port, registered read data.
module odfq_mem #(
   parameter int DEPTH = odfq_pkg::QUEUE_DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  odfq_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output odfq_pkg::entry_type rd_data
);
   import odfq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/odfq_mod.sv]
// Bit-serial remainder unit: push counter modulo the decimation divisor.
module odfq_mod #(
   parameter int DIV_W = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [odfq_pkg::CTR_W-1:0] dividend,
   input  logic [DIV_W-1:0]           divisor,
   output odfq_pkg::mod_status_type   status
);
   import odfq_pkg::*;

   localparam int STEP_W = $clog2(CTR_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [CTR_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W:0]    shifted;

   // One restoring step per cycle, MSB first
   always_comb begin
      shifted  = {rem_ff, dvd_ff[CTR_W-1]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         steps_in = STEP_W'(CTR_W);
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[CTR_W-2:0], 1'b0};
         steps_in = steps_ff - STEP_W'(1);
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = DIV_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[DIV_W-1:0];
         end
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

endmodule

[hw/rtl/occupancy_decimating_frame_queue_top.sv]
// Occupancy-decimating frame queue top level. A FIFO of frame descriptors
// held in one synchronous memory. A push keeps every frame while the queue
// holds fewer than DECIM_STEP entries, every second below twice that, and so
// on, by testing the push counter modulo (occupancy/DECIM_STEP + 1) in a
// bit-serial remainder unit; end-of-stream descriptors that reach it are
// always kept while room remains. One transaction is worked at a time: a
// push passes S_DIVIDE and a pop S_READ (one memory read) before
// S_FINISH; a rejected push or an empty pop goes straight to S_FINISH.
// The next transaction is taken as soon as the result sits in the output
// register, even while that result waits to be read. latest_only and
// allow_drop live at byte addresses 0 and 4 of the register port, written
// by the user only while the queue is idle; the block does not check it.
`include "occupancy_decimating_frame_queue_top_macros.svh"
module occupancy_decimating_frame_queue_top #(
   parameter int DECIM_STEP  = odfq_pkg::DECIM_STEP_DEF,
   parameter int QUEUE_DEPTH = odfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  odfq_pkg::req_type req_data,
   // Response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output odfq_pkg::rsp_type rsp_data,
   // Register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import odfq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_W = $clog2(QUEUE_DEPTH / DECIM_STEP + 2);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DIVIDE = 4'b0010,
      S_READ   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CTR_W-1:0]    counter_ff, counter_in;
   logic                latest_only_ff, latest_only_in;
   logic                allow_drop_ff, allow_drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   entry_type           push_ff, push_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   entry_type           res_head_ff, res_head_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                req_accept;
   logic                csr_write;
   logic [CNT_W-1:0]    fill_eff;
   logic [IDX_W-1:0]    tail_eff;
   logic                mem_wr_en;
   logic                mem_rd_en;
   entry_type           mem_rd_data;
   logic                mod_start;
   logic [DIV_W-1:0]    mod_divisor;
   mod_status_type      mod_st;
   logic [DIV_W-1:0]    div_table [QUEUE_DEPTH+1];

   // Divisor per occupancy, fixed at elaboration
   for (genvar i = 0; i <= QUEUE_DEPTH; i++) begin : g_div
      assign div_table[i] = DIV_W'(i / DECIM_STEP + 1);
   end

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Queue view after an optional latest-only clear
   assign fill_eff    = latest_only_ff ? '0 : fill_ff;
   assign tail_eff    = latest_only_ff ? head_ff : tail_ff;
   assign mod_divisor = div_table[fill_eff];

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == REG_ALLOW_DROP) ? {31'b0, allow_drop_ff}
                                                   : {31'b0, latest_only_ff};

   always_comb begin
      latest_only_in = latest_only_ff;
      allow_drop_in  = allow_drop_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_LATEST_ONLY: latest_only_in = pwdata[0];
            REG_ALLOW_DROP:  allow_drop_in  = pwdata[0];
            default:         latest_only_in = latest_only_ff;
         endcase
      end
   end

   // Sequencer: read or modify the queue, then hand the result out
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      counter_in    = counter_ff;
      push_in       = push_ff;
      res_status_in = res_status_ff;
      res_head_in   = res_head_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mod_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               push_in.capture_time  = req_data.capture_time;
               push_in.display_time  = req_data.display_time;
               push_in.frame_handle  = req_data.frame_handle;
               push_in.end_marker    = req_data.end_marker;
               res_head_in           = '0;
               if (req_data.command == CMD_PUSH) begin
                  fill_in = fill_eff;
                  tail_in = tail_eff;
                  if (!allow_drop_ff && (32'(fill_eff) >= 32'(DECIM_STEP))) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     mod_start = 1'b1;
                     state_in  = S_DIVIDE;
                  end
               end else if (fill_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  state_in      = S_FINISH;
               end else begin
                  mem_rd_en = 1'b1;
                  state_in  = S_READ;
               end
            end
         end
         S_DIVIDE: begin
            if (mod_st.done) begin
               counter_in = counter_ff + CTR_W'(1);
               if ((mod_st.zero || push_ff.end_marker) &&
                   (fill_ff < CNT_W'(QUEUE_DEPTH))) begin
                  mem_wr_en     = 1'b1;
                  tail_in       = next_slot(tail_ff);
                  fill_in       = fill_ff + CNT_W'(1);
                  res_status_in = STATUS_ACCEPTED;
               end else begin
                  res_status_in = STATUS_DROPPED;
               end
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            res_head_in   = mem_rd_data;
            head_in       = next_slot(head_ff);
            fill_in       = fill_ff - CNT_W'(1);
            res_status_in = STATUS_POPPED;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.status             = res_status_ff;
               rsp_data_in.head_capture_time  = res_head_ff.capture_time;
               rsp_data_in.head_display_time  = res_head_ff.display_time;
               rsp_data_in.head_frame_handle  = res_head_ff.frame_handle;
               rsp_data_in.head_end_marker    = res_head_ff.end_marker;
               rsp_data_in.occupancy          = OCC_W'(fill_ff);
               state_in                       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_ff        <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         counter_ff     <= '0;
         latest_only_ff <= 1'b0;
         allow_drop_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fill_ff        <= fill_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         counter_ff     <= counter_in;
         latest_only_ff <= latest_only_in;
         allow_drop_ff  <= allow_drop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      push_ff       <= push_in;
      res_status_ff <= res_status_in;
      res_head_ff   <= res_head_in;
      rsp_data_ff   <= rsp_data_in;
   end

   odfq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (tail_ff),
      .wr_data (push_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (head_ff),
      .rd_data (mem_rd_data)
   );

   odfq_mod #(
      .DIV_W (DIV_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (counter_ff),
      .divisor  (mod_divisor),
      .status   (mod_st)
   );

   // Checks
   `ODFQ_ASSERT_NOW(a_fill_cap, clock, reset, 1'b1, fill_ff <= CNT_W'(QUEUE_DEPTH))
   `ODFQ_ASSERT_NOW(a_mem_one_port, clock, reset, mem_wr_en, !mem_rd_en)
   `ODFQ_ASSERT_NEXT(a_read_follow, clock, reset, mem_rd_en, state_ff == S_READ)
   `ODFQ_ASSERT_NOW(a_mod_done_state, clock, reset, mod_st.done, state_ff == S_DIVIDE)

endmodule
